>>> sv/mesh_direction_mask_generator_unit_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef MESH_DIRECTION_MASK_GENERATOR_UNIT_MACROS_SVH
`define MESH_DIRECTION_MASK_GENERATOR_UNIT_MACROS_SVH

// Clocked property that is switched off while the reset is asserted.
`define MDMG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is checked through reset as well.
`define MDMG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mdmg_pkg.sv
`timescale 1ns / 1ps

package mdmg_pkg;

  // Largest mesh that fits the node bitmask.
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CoordW   = 6;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned ProdW    = 2 * SizeW;
  localparam int unsigned TotalW   = 3 * SizeW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned NumDirs  = 7;

  // Reset values of the size registers.
  localparam logic [SizeW-1:0] SizeXReset = SizeW'(4);
  localparam logic [SizeW-1:0] SizeYReset = SizeW'(4);
  localparam logic [SizeW-1:0] SizeZReset = SizeW'(1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  // Output port a node falls under; also the row of the working masks.
  typedef enum logic [2:0] {
    DIR_X_PLUS  = 3'd0,
    DIR_X_MINUS = 3'd1,
    DIR_Y_PLUS  = 3'd2,
    DIR_Y_MINUS = 3'd3,
    DIR_Z_PLUS  = 3'd4,
    DIR_Z_MINUS = 3'd5,
    DIR_LOCAL   = 3'd6
  } dir_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [MaxNodes-1:0] mask_x_plus;
    logic [MaxNodes-1:0] mask_x_minus;
    logic [MaxNodes-1:0] mask_y_plus;
    logic [MaxNodes-1:0] mask_y_minus;
    logic [MaxNodes-1:0] mask_z_plus;
    logic [MaxNodes-1:0] mask_z_minus;
    logic [MaxNodes-1:0] mask_local;
    logic                bad_setting;
  } out_item_t;

endpackage

>>> sv/mesh_direction_mask_generator_unit.sv
`timescale 1ns / 1ps
// An accepted beat passes the product and check states, then walks the N nodes of the mesh
// (1 to 64) before its result is loaded; an unusable setting or position skips the walk.
// No new beat is taken until the current result is loaded; the walk goes one node per cycle
// through a single shared compare unit; the product and check states before it form the node count.
// Reset: sizes return to 4 x 4 x 1, the sequencer goes idle and no result is held.
module mesh_direction_mask_generator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mdmg_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mdmg_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mdmg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mdmg_pkg::SizeW-1:0]      cfg_data_i
);
  import mdmg_pkg::*;

  state_e state_q, state_d;

  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q;
  in_item_t         pos_q;
  logic [ProdW-1:0] prod_q;
  logic [TotalW-1:0] total;
  logic             bad_now;
  logic             bad_q;

  logic [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [NodeW-1:0]  node_q;
  logic              x_last, y_last, z_last, walk_last;
  dir_e              dir_sel;

  logic [MaxNodes-1:0] wmask_q [NumDirs];

  logic      accept_in;
  logic      load_out;
  logic      out_valid_q;
  out_item_t out_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeXReset;
      size_y_q <= SizeYReset;
      size_z_q <= SizeZReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Node count from the partial product and the checks on the position.
  assign total   = TotalW'(prod_q) * TotalW'(size_z_q);
  assign bad_now = (total > TotalW'(MaxNodes))
                || ({1'b0, pos_q.pos_x} >= size_x_q)
                || ({1'b0, pos_q.pos_y} >= size_y_q)
                || ({1'b0, pos_q.pos_z} >= size_z_q);

  // End of each coordinate run during the walk.
  assign x_last    = ({1'b0, cx_q} == size_x_q - SizeW'(1));
  assign y_last    = ({1'b0, cy_q} == size_y_q - SizeW'(1));
  assign z_last    = ({1'b0, cz_q} == size_z_q - SizeW'(1));
  assign walk_last = x_last && y_last && z_last;

  // Shared compare unit: dimension order decides the port of the current node.
  always_comb begin
    priority if (cx_q > pos_q.pos_x) begin
      dir_sel = DIR_X_PLUS;
    end else if (cx_q < pos_q.pos_x) begin
      dir_sel = DIR_X_MINUS;
    end else if (cy_q > pos_q.pos_y) begin
      dir_sel = DIR_Y_PLUS;
    end else if (cy_q < pos_q.pos_y) begin
      dir_sel = DIR_Y_MINUS;
    end else if (cz_q > pos_q.pos_z) begin
      dir_sel = DIR_Z_PLUS;
    end else if (cz_q < pos_q.pos_z) begin
      dir_sel = DIR_Z_MINUS;
    end else begin
      dir_sel = DIR_LOCAL;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PROD;
      ST_PROD:  state_d = ST_CHECK;
      ST_CHECK: state_d = bad_now ? ST_DONE : ST_WALK;
      ST_WALK:  if (walk_last) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept_in  = (state_q == ST_IDLE) && in_valid_i;
    load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the position, form the first partial product, then walk the nodes.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      pos_q  <= in_item_i;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      node_q <= '0;
      bad_q  <= 1'b0;
      for (int d = 0; d < NumDirs; d++) begin
        wmask_q[d] <= '0;
      end
    end
    if (state_q == ST_PROD) begin
      prod_q <= ProdW'(size_x_q) * ProdW'(size_y_q);
    end
    if (state_q == ST_CHECK) begin
      bad_q <= bad_now;
    end
    if (state_q == ST_WALK) begin
      wmask_q[dir_sel][node_q] <= 1'b1;
      node_q <= node_q + NodeW'(1);
      if (x_last) begin
        cx_q <= '0;
        if (y_last) begin
          cy_q <= '0;
          cz_q <= cz_q + CoordW'(1);
        end else begin
          cy_q <= cy_q + CoordW'(1);
        end
      end else begin
        cx_q <= cx_q + CoordW'(1);
      end
    end
  end

  // Output register, so the next beat can start while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.mask_x_plus  <= wmask_q[DIR_X_PLUS];
      out_q.mask_x_minus <= wmask_q[DIR_X_MINUS];
      out_q.mask_y_plus  <= wmask_q[DIR_Y_PLUS];
      out_q.mask_y_minus <= wmask_q[DIR_Y_MINUS];
      out_q.mask_z_plus  <= wmask_q[DIR_Z_PLUS];
      out_q.mask_z_minus <= wmask_q[DIR_Z_MINUS];
      out_q.mask_local   <= wmask_q[DIR_LOCAL];
      out_q.bad_setting  <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/mdmg_checker.sv
`timescale 1ns / 1ps
`include "mesh_direction_mask_generator_unit_macros.svh"

module mdmg_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  mdmg_pkg::out_item_t          out_item_o
);
  import mdmg_pkg::*;

  // A result that is held back stays offered.
  `MDMG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped while stalled")

  // An accepted beat occupies the block for the following cycle.
  `MDMG_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "block ready right after accepting a beat")

  // A new result only appears at the end of a busy spell.
  `MDMG_ASSERT(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without work in progress")

  // An error result carries no mask bits; a good one names exactly one local node.
  `MDMG_ASSERT(a_result_shape, clk_i, rst_ni, out_valid_o |-> (out_item_o.bad_setting ? ((out_item_o.mask_x_plus | out_item_o.mask_x_minus | out_item_o.mask_y_plus | out_item_o.mask_y_minus | out_item_o.mask_z_plus | out_item_o.mask_z_minus | out_item_o.mask_local) == '0) : $onehot(out_item_o.mask_local)), "malformed result beat")

endmodule

bind mesh_direction_mask_generator_unit mdmg_checker u_mdmg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

>>> dv/mesh_direction_mask_generator_unit_tb.sv
`timescale 1ns / 1ps

module mesh_direction_mask_generator_unit_tb;
  import mdmg_pkg::*;

  // Index past the last size register; the block drops writes to it.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  // Long receiver hold-off used to back the block up into its input.
  localparam int unsigned HoldCycles = 300;
  // Longest walk (64 nodes) plus the set-up cycles, with some margin.
  localparam int unsigned SettleCycles = 80;

  // Keeps its own copy of the mesh sizes and the masks still owed by the block.
  class route_mask_scoreboard;
    logic [SizeW-1:0] size_x;
    logic [SizeW-1:0] size_y;
    logic [SizeW-1:0] size_z;
    out_item_t masks_due[$];
    int unsigned mismatches;

    function new();
      size_x = SizeXReset;
      size_y = SizeYReset;
      size_z = SizeZReset;
      mismatches = 0;
    endfunction

    // A write to an index past the size registers leaves the sizes alone.
    function void set_size(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] data);
      case (idx)
        REG_SIZE_X: size_x = data;
        REG_SIZE_Y: size_y = data;
        REG_SIZE_Z: size_z = data;
        default: ;
      endcase
    endfunction

    // Dimension-ordered masks for one router, walking nodes in numbering order.
    function out_item_t route_masks(in_item_t pos);
      out_item_t res;
      int unsigned px, py, pz;
      int unsigned sx, sy, sz;
      int unsigned node;
      dir_e dir;
      res = '0;
      px = int'(pos.pos_x);
      py = int'(pos.pos_y);
      pz = int'(pos.pos_z);
      sx = int'(size_x);
      sy = int'(size_y);
      sz = int'(size_z);
      // An oversized mesh or a position off the mesh yields only the error flag.
      if (sx * sy * sz > MaxNodes || px >= sx || py >= sy || pz >= sz) begin
        res.bad_setting = 1'b1;
        return res;
      end
      node = 0;
      for (int unsigned z = 0; z < sz; z++) begin
        for (int unsigned y = 0; y < sy; y++) begin
          for (int unsigned x = 0; x < sx; x++) begin
            if (x > px) dir = DIR_X_PLUS;
            else if (x < px) dir = DIR_X_MINUS;
            else if (y > py) dir = DIR_Y_PLUS;
            else if (y < py) dir = DIR_Y_MINUS;
            else if (z > pz) dir = DIR_Z_PLUS;
            else if (z < pz) dir = DIR_Z_MINUS;
            else dir = DIR_LOCAL;
            case (dir)
              DIR_X_PLUS:  res.mask_x_plus[node]  = 1'b1;
              DIR_X_MINUS: res.mask_x_minus[node] = 1'b1;
              DIR_Y_PLUS:  res.mask_y_plus[node]  = 1'b1;
              DIR_Y_MINUS: res.mask_y_minus[node] = 1'b1;
              DIR_Z_PLUS:  res.mask_z_plus[node]  = 1'b1;
              DIR_Z_MINUS: res.mask_z_minus[node] = 1'b1;
              default:     res.mask_local[node]   = 1'b1;
            endcase
            node++;
          end
        end
      end
      return res;
    endfunction

    function void note_router(in_item_t pos);
      masks_due.push_back(route_masks(pos));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Checks one result beat against the oldest set of masks owed.
    function void check_masks(out_item_t got);
      out_item_t want;
      if (masks_due.size() == 0) begin
        $display("%0t: result beat with no router pending, expected none, got %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = masks_due.pop_front();
      compare_field("mask_x_plus", want.mask_x_plus, got.mask_x_plus);
      compare_field("mask_x_minus", want.mask_x_minus, got.mask_x_minus);
      compare_field("mask_y_plus", want.mask_y_plus, got.mask_y_plus);
      compare_field("mask_y_minus", want.mask_y_minus, got.mask_y_minus);
      compare_field("mask_z_plus", want.mask_z_plus, got.mask_z_plus);
      compare_field("mask_z_minus", want.mask_z_minus, got.mask_z_minus);
      compare_field("mask_local", want.mask_local, got.mask_local);
      compare_field("bad_setting", 64'(want.bad_setting), 64'(got.bad_setting));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SizeW-1:0]   cfg_data_i = '0;

  // When set, neither side idles or stalls at random.
  bit quiet = 1'b0;
  // Asks the result side for one long hold-off.
  bit hold_long = 1'b0;
  route_mask_scoreboard board;

  mesh_direction_mask_generator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin : watchdog
    #10ms;
    $display("mesh_direction_mask_generator_unit_tb NOT OK");
    $finish;
  end

  function automatic int unsigned idle_draw();
    return quiet ? 0 : $urandom_range(9);
  endfunction

  // A coordinate inside the given extent, or anywhere in the field for noise.
  function automatic logic [CoordW-1:0] pick_coord(logic [SizeW-1:0] extent, bit noise);
    if (noise || extent == 0 || int'(extent) > MaxNodes) begin
      return CoordW'($urandom_range(63));
    end
    return CoordW'($urandom_range(int'(extent) - 1));
  endfunction

  // Offers one router position and waits for the block to take the beat.
  task automatic send_router(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                             input logic [CoordW-1:0] z);
    in_item_t item;
    int unsigned gap;
    item.pos_x = x;
    item.pos_y = y;
    item.pos_z = z;
    gap = idle_draw();
    if (gap != 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_router(item);
  endtask

  // Stops offering and waits until every owed result has arrived.
  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (board.masks_due.size() != 0) @(posedge clk_i);
  endtask

  // One register write beat; the valid is dropped only after the last of a group.
  task automatic write_size(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] data,
                            input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_size(idx, data);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mesh(input logic [SizeW-1:0] sx, input logic [SizeW-1:0] sy,
                          input logic [SizeW-1:0] sz);
    drain();
    write_size(REG_SIZE_X, sx, 1'b0);
    write_size(REG_SIZE_Y, sy, 1'b0);
    write_size(REG_SIZE_Z, sz, 1'b1);
  endtask

  // Mostly usable meshes, with some oversized, zero-sized and dropped writes.
  task automatic pick_mesh();
    int unsigned kind, a, b, c;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      a = $urandom_range(1, $urandom_range(1, 64));
      b = $urandom_range(1, 64 / a);
      c = $urandom_range(1, 64 / (a * b));
      case ($urandom_range(2))
        0: set_mesh(SizeW'(a), SizeW'(b), SizeW'(c));
        1: set_mesh(SizeW'(c), SizeW'(a), SizeW'(b));
        default: set_mesh(SizeW'(b), SizeW'(c), SizeW'(a));
      endcase
    end else if (kind == 7) begin
      set_mesh(SizeW'($urandom_range(5, 127)), SizeW'($urandom_range(13, 127)),
               SizeW'($urandom_range(1, 127)));
    end else if (kind == 8) begin
      a = $urandom_range(2);
      set_mesh(a == 0 ? '0 : SizeW'($urandom_range(127)),
               a == 1 ? '0 : SizeW'($urandom_range(127)),
               a == 2 ? '0 : SizeW'($urandom_range(127)));
    end else begin
      drain();
      write_size(RegUnused, SizeW'($urandom_range(127)), 1'b1);
    end
  endtask

  // Result side: random stalls per beat, with one long hold-off on request.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni);
    forever begin
      if (hold_long) begin
        hold = HoldCycles;
        hold_long = 1'b0;
      end else begin
        hold = idle_draw();
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      board.check_masks(out_item_o);
    end
  end

  // Stimulus: directed corners, a back-pressure burst, then random phases.
  initial begin : stimulus
    bit noise;
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: corners and each coordinate just off the mesh.
    send_router(6'd0, 6'd0, 6'd0);
    send_router(6'd3, 6'd3, 6'd0);
    send_router(6'd1, 6'd2, 6'd0);
    send_router(6'd4, 6'd0, 6'd0);
    send_router(6'd0, 6'd4, 6'd0);
    send_router(6'd0, 6'd0, 6'd1);
    send_router(6'd63, 6'd63, 6'd63);

    // A full cube of 64 nodes.
    set_mesh(7'd4, 7'd4, 7'd4);
    send_router(6'd0, 6'd0, 6'd0);
    send_router(6'd3, 6'd3, 6'd3);
    send_router(6'd1, 6'd2, 6'd3);
    send_router(6'd2, 6'd1, 6'd0);

    // Single lines along each dimension, at full length.
    set_mesh(7'd64, 7'd1, 7'd1);
    send_router(6'd63, 6'd0, 6'd0);
    send_router(6'd0, 6'd0, 6'd0);
    send_router(6'd32, 6'd0, 6'd0);
    set_mesh(7'd1, 7'd1, 7'd64);
    send_router(6'd0, 6'd0, 6'd63);
    send_router(6'd0, 6'd0, 6'd0);
    set_mesh(7'd1, 7'd64, 7'd1);
    send_router(6'd0, 6'd63, 6'd0);

    // A lone node, and a position beside it.
    set_mesh(7'd1, 7'd1, 7'd1);
    send_router(6'd0, 6'd0, 6'd0);
    send_router(6'd1, 6'd0, 6'd0);

    // Meshes too large for the mask, and a zero size.
    set_mesh(7'd5, 7'd5, 7'd3);
    send_router(6'd0, 6'd0, 6'd0);
    set_mesh(7'd127, 7'd1, 7'd1);
    send_router(6'd0, 6'd0, 6'd0);
    set_mesh(7'd0, 7'd4, 7'd1);
    send_router(6'd0, 6'd0, 6'd0);

    // A write past the size registers must leave the 2 x 2 x 2 mesh intact.
    set_mesh(7'd2, 7'd2, 7'd2);
    @(posedge clk_i);
    write_size(RegUnused, 7'd0, 1'b1);
    send_router(6'd1, 6'd1, 6'd1);

    // Back-pressure: the sink holds off while beats keep coming.
    set_mesh(7'd4, 7'd4, 7'd1);
    hold_long = 1'b1;
    quiet = 1'b1;
    repeat (12) begin
      send_router(pick_coord(board.size_x, 1'b0), pick_coord(board.size_y, 1'b0),
                  pick_coord(board.size_z, 1'b0));
    end
    quiet = 1'b0;
    drain();

    // Random phases, each with its own mesh and idling mode.
    repeat (16) begin
      pick_mesh();
      quiet = ($urandom_range(3) == 0);
      repeat (25) begin
        noise = ($urandom_range(7) == 0);
        send_router(pick_coord(board.size_x, noise), pick_coord(board.size_y, noise),
                    pick_coord(board.size_z, noise));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.masks_due.size() == 0) begin
      $display("mesh_direction_mask_generator_unit_tb OK");
    end else begin
      $display("mesh_direction_mask_generator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
